// ===== hdl/draw_area_scanout_hazard_tracker_assert.svh =====
// Assertion macros used by the tracker top level.
`ifndef DRAW_AREA_SCANOUT_HAZARD_TRACKER_ASSERT_SVH
`define DRAW_AREA_SCANOUT_HAZARD_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on clk_i, off while rst_ni is low.
`define DASH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on clk_i at every edge, reset included.
`define DASH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DASH_ASSERT(lbl, prop, msg)
`define DASH_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/dash_pkg.sv =====
// Types and constants of the draw-area scanout hazard tracker.
`timescale 1ns / 1ps
package dash_pkg;

  localparam int unsigned PosW = 32;
  localparam int unsigned XW   = 10;
  localparam int unsigned YW   = 9;
  localparam int unsigned X1W  = 11;
  localparam int unsigned Y1W  = 10;

  // Scanout extents beyond these wrap around VRAM.
  localparam logic [X1W-1:0] ScanXLimit = 11'd1024;
  localparam logic [Y1W-1:0] ScanYLimit = 10'd512;

  typedef enum logic [1:0] {
    REQ_ADD_RECT  = 2'd0,
    REQ_ADD_WORDS = 2'd1,
    REQ_SCAN      = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    DEC_NONE = 2'd0,
    DEC_WAIT = 2'd1,
    DEC_FULL = 2'd2
  } decision_e;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [XW-1:0]   left;
    logic [YW-1:0]   top;
    logic [X1W-1:0]  right;
    logic [Y1W-1:0]  bottom;
  } area_t;

  typedef struct packed {
    logic [XW-1:0]   sx0;
    logic [YW-1:0]   sy0;
    logic [X1W-1:0]  sx1;
    logic [Y1W-1:0]  sy1;
    logic [PosW-1:0] used;
  } query_t;

  // Walk token handed from cell to cell.
  typedef struct packed {
    logic            vld;
    logic            done;
    logic            head;
    decision_e       dec;
    logic [PosW-1:0] tgt;
  } token_t;

endpackage

// ===== hdl/dash_cell.sv =====
// One ring entry of the tracker plus its stage of the scanout walk.
`timescale 1ns / 1ps
module dash_cell
  import dash_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   ld_i,
  input  area_t  nbr_i,
  output area_t  ent_o,
  input  query_t qry_i,
  input  token_t tok_i,
  output token_t tok_o
);

  area_t  ent_q;
  token_t tok_q, tok_d;
  logic   xmiss, ymiss, retired;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else if (ld_i) begin
      ent_q <= nbr_i;
    end
  end

  assign xmiss   = (qry_i.sx1 <= {1'b0, ent_q.left}) || (ent_q.right <= {1'b0, qry_i.sx0});
  assign ymiss   = (qry_i.sy1 <= {1'b0, ent_q.top}) || (ent_q.bottom <= {1'b0, qry_i.sy0});
  assign retired = qry_i.used >= ent_q.pos;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.done) begin
      tok_d.head = 1'b0;
      if (!xmiss && !ymiss) begin
        tok_d.done = 1'b1;
        if (tok_i.head) begin
          tok_d.dec = DEC_FULL;
          tok_d.tgt = '0;
        end else begin
          // nbr_i is the next newer entry here
          tok_d.dec = DEC_WAIT;
          tok_d.tgt = nbr_i.pos + 32'd1;
        end
      end else if (retired) begin
        tok_d.done = 1'b1;
        tok_d.dec  = DEC_NONE;
        tok_d.tgt  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign ent_o = ent_q;
  assign tok_o = tok_q;

endmodule

// ===== hdl/draw_area_scanout_hazard_tracker.sv =====
// Top level of the draw-area scanout hazard tracker.
//
//   channel | direction | handshake              | payload
//   in      | sink      | in_valid_i / in_ready_o | req_type_i .. consumer_idle_i
//   out     | source    | out_valid_o / out_ready_i | decision_o, target_pos_o
//
// Add beats leave the block ready; the next beat is taken in the following cycle.
// A scanout check walks a token down the row of AREA_ENTRIES cells, one cell a
// cycle, through the launch register and each cell's token register, and its
// result is then registered in the output register; no beat is taken until the
// result has entered the output register. Reset clears all entries to zero at
// once. A stalled output holds one more result in a holding register.
`timescale 1ns / 1ps
`include "draw_area_scanout_hazard_tracker_assert.svh"
module draw_area_scanout_hazard_tracker
  import dash_pkg::*;
#(
  parameter int unsigned AREA_ENTRIES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       req_type_i,
  input  logic [PosW-1:0]  stream_pos_i,
  input  logic             force_new_i,
  input  logic [XW-1:0]    rect_x0_i,
  input  logic [YW-1:0]    rect_y0_i,
  input  logic [X1W-1:0]   rect_x1_i,
  input  logic [Y1W-1:0]   rect_y1_i,
  input  logic [31:0]      area_word_tl_i,
  input  logic [31:0]      area_word_br_i,
  input  logic [PosW-1:0]  consumed_pos_i,
  input  logic [PosW-1:0]  added_pos_i,
  input  logic             consumer_idle_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       decision_o,
  output logic [PosW-1:0]  target_pos_o
);

  area_t  ent [AREA_ENTRIES];
  token_t tok [AREA_ENTRIES];

  area_t           new_area;
  logic            accept, add_acc, scan_acc, open_new;
  logic [PosW-1:0] pos_diff;
  query_t          qry_q;
  token_t          launch_q, launch_d;
  token_t          tail;
  decision_e       res_dec;
  logic [PosW-1:0] res_tgt;
  logic            busy_q, busy_d;
  logic            hold_vld_q, hold_vld_d;
  decision_e       hold_dec_q, hold_dec_d;
  logic [PosW-1:0] hold_tgt_q, hold_tgt_d;
  logic            out_vld_q, out_vld_d;
  decision_e       out_dec_q, out_dec_d;
  logic [PosW-1:0] out_tgt_q, out_tgt_d;
  logic            out_free;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    add_acc  = 1'b0;
    scan_acc = 1'b0;
    new_area = '0;
    new_area.pos = stream_pos_i;
    unique case (req_type_i)
      REQ_ADD_RECT: begin
        add_acc         = accept;
        new_area.left   = rect_x0_i;
        new_area.top    = rect_y0_i;
        new_area.right  = rect_x1_i;
        new_area.bottom = rect_y1_i;
      end
      REQ_ADD_WORDS: begin
        // bottom-right word holds an inclusive corner
        add_acc         = accept;
        new_area.left   = area_word_tl_i[9:0];
        new_area.top    = area_word_tl_i[18:10];
        new_area.right  = {1'b0, area_word_br_i[9:0]} + 11'd1;
        new_area.bottom = {1'b0, area_word_br_i[18:10]} + 10'd1;
      end
      REQ_SCAN: scan_acc = accept;
      default: ;
    endcase
  end

  assign pos_diff = stream_pos_i - ent[0].pos;
  assign open_new = force_new_i || (pos_diff[PosW-1:1] != '0);

  // Cell 0 is the newest entry, the last cell the oldest; opening an entry
  // shifts the whole row by one.
  for (genvar k = 0; k < AREA_ENTRIES; k++) begin : g_cell
    if (k == 0) begin : g_head
      dash_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ld_i   (add_acc),
        .nbr_i  (new_area),
        .ent_o  (ent[k]),
        .qry_i  (qry_q),
        .tok_i  (launch_q),
        .tok_o  (tok[k])
      );
    end else begin : g_body
      dash_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ld_i   (add_acc && open_new),
        .nbr_i  (ent[k-1]),
        .ent_o  (ent[k]),
        .qry_i  (qry_q),
        .tok_i  (tok[k-1]),
        .tok_o  (tok[k])
      );
    end
  end

  // Early verdicts ride the chain already done, so every check has one latency.
  always_comb begin
    launch_d      = '0;
    launch_d.vld  = scan_acc;
    launch_d.head = 1'b1;
    launch_d.dec  = DEC_NONE;
    if (consumer_idle_i && (added_pos_i == consumed_pos_i)) begin
      launch_d.done = 1'b1;
    end else if (consumer_idle_i || (rect_x1_i > ScanXLimit) || (rect_y1_i > ScanYLimit)
                 || (ent[AREA_ENTRIES-1].pos > consumed_pos_i)) begin
      launch_d.done = 1'b1;
      launch_d.dec  = DEC_FULL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_acc) begin
      qry_q.sx0  <= rect_x0_i;
      qry_q.sy0  <= rect_y0_i;
      qry_q.sx1  <= rect_x1_i;
      qry_q.sy1  <= rect_y1_i;
      qry_q.used <= consumed_pos_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else begin
      launch_q <= launch_d;
    end
  end

  // A token that ran off the end without a verdict points past the oldest entry.
  assign tail    = tok[AREA_ENTRIES-1];
  assign res_dec = tail.done ? tail.dec : DEC_WAIT;
  assign res_tgt = tail.done ? tail.tgt : (ent[AREA_ENTRIES-1].pos + 32'd1);

  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    busy_d     = busy_q;
    hold_vld_d = hold_vld_q;
    hold_dec_d = hold_dec_q;
    hold_tgt_d = hold_tgt_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_dec_d  = out_dec_q;
    out_tgt_d  = out_tgt_q;
    if (scan_acc) begin
      busy_d = 1'b1;
    end
    if (hold_vld_q) begin
      if (out_free) begin
        out_vld_d  = 1'b1;
        out_dec_d  = hold_dec_q;
        out_tgt_d  = hold_tgt_q;
        hold_vld_d = 1'b0;
        busy_d     = 1'b0;
      end
    end else if (tail.vld) begin
      if (out_free) begin
        out_vld_d = 1'b1;
        out_dec_d = res_dec;
        out_tgt_d = res_tgt;
        busy_d    = 1'b0;
      end else begin
        hold_vld_d = 1'b1;
        hold_dec_d = res_dec;
        hold_tgt_d = res_tgt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_dec_q <= hold_dec_d;
    hold_tgt_q <= hold_tgt_d;
    out_dec_q  <= out_dec_d;
    out_tgt_q  <= out_tgt_d;
  end

  assign out_valid_o  = out_vld_q;
  assign decision_o   = out_dec_q;
  assign target_pos_o = out_tgt_q;

  `DASH_ASSERT(a_tail_no_hold, tail.vld |-> !hold_vld_q, "walk result while hold occupied")
  `DASH_ASSERT(a_ring_frozen, busy_q |=> $stable(ent[0].pos), "ring changed during walk")
  `DASH_ASSERT(a_tail_latency, tail.vld |-> $past(launch_q.vld, AREA_ENTRIES),
               "walk latency mismatch")
  `DASH_ASSERT(a_target_zero, out_valid_o && (decision_o != DEC_WAIT) |-> target_pos_o == '0,
               "target set without wait decision")
  `DASH_ASSERT_ALWAYS(a_hold_busy, hold_vld_q |-> busy_q, "held result while not busy")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the draw-area scanout hazard tracker.
`timescale 1ns / 1ps
module testbench;
  import dash_pkg::*;

  localparam int unsigned AREA_N = 8;
  localparam logic [1:0] ReqUnused = 2'd3;

  typedef struct {
    logic [1:0]      kind;
    logic [PosW-1:0] pos;
    logic            fresh;
    logic [XW-1:0]   x0;
    logic [YW-1:0]   y0;
    logic [X1W-1:0]  x1;
    logic [Y1W-1:0]  y1;
    logic [31:0]     tl;
    logic [31:0]     br;
    logic [PosW-1:0] used;
    logic [PosW-1:0] added;
    logic            idle;
  } draw_req_t;

  typedef struct {
    decision_e       dec;
    logic [PosW-1:0] tgt;
  } scan_verdict_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [1:0]      req_type_i = '0;
  logic [PosW-1:0] stream_pos_i = '0;
  logic            force_new_i = 1'b0;
  logic [XW-1:0]   rect_x0_i = '0;
  logic [YW-1:0]   rect_y0_i = '0;
  logic [X1W-1:0]  rect_x1_i = '0;
  logic [Y1W-1:0]  rect_y1_i = '0;
  logic [31:0]     area_word_tl_i = '0;
  logic [31:0]     area_word_br_i = '0;
  logic [PosW-1:0] consumed_pos_i = '0;
  logic [PosW-1:0] added_pos_i = '0;
  logic            consumer_idle_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [1:0]      decision_o;
  logic [PosW-1:0] target_pos_o;

  draw_area_scanout_hazard_tracker #(
    .AREA_ENTRIES(AREA_N)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .stream_pos_i   (stream_pos_i),
    .force_new_i    (force_new_i),
    .rect_x0_i      (rect_x0_i),
    .rect_y0_i      (rect_y0_i),
    .rect_x1_i      (rect_x1_i),
    .rect_y1_i      (rect_y1_i),
    .area_word_tl_i (area_word_tl_i),
    .area_word_br_i (area_word_br_i),
    .consumed_pos_i (consumed_pos_i),
    .added_pos_i    (added_pos_i),
    .consumer_idle_i(consumer_idle_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .decision_o     (decision_o),
    .target_pos_o   (target_pos_o)
  );

  always #6 clk_i = ~clk_i;

  // Mirror of the area ring.
  logic [PosW-1:0] ring_pos    [AREA_N];
  logic [XW-1:0]   ring_left   [AREA_N];
  logic [YW-1:0]   ring_top    [AREA_N];
  logic [X1W-1:0]  ring_right  [AREA_N];
  logic [Y1W-1:0]  ring_bottom [AREA_N];
  int unsigned     newest_slot;

  draw_req_t     req_queue[$];
  scan_verdict_t exp_verdicts[$];
  int            errors = 0;

  function automatic void record_area(logic [PosW-1:0] pos, logic fresh, logic [XW-1:0] l,
                                      logic [YW-1:0] t, logic [X1W-1:0] r,
                                      logic [Y1W-1:0] b);
    int unsigned n;
    n = newest_slot;
    if ((pos - ring_pos[n]) > 32'd1 || fresh)
      n = (n + 1) % AREA_N;
    newest_slot    = n;
    ring_pos[n]    = pos;
    ring_left[n]   = l;
    ring_top[n]    = t;
    ring_right[n]  = r;
    ring_bottom[n] = b;
  endfunction

  function automatic scan_verdict_t predict_scan(draw_req_t rq);
    scan_verdict_t res;
    int unsigned   i;
    int unsigned   c;
    logic          xmiss;
    logic          ymiss;
    res.dec = DEC_NONE;
    res.tgt = '0;
    i = newest_slot;
    if (rq.idle && rq.added == rq.used)
      return res;
    if (rq.idle || rq.x1 > ScanXLimit || rq.y1 > ScanYLimit) begin
      res.dec = DEC_FULL;
      return res;
    end
    // oldest entry compared without wrap
    if (ring_pos[(i + 1) % AREA_N] > rq.used) begin
      res.dec = DEC_FULL;
      return res;
    end
    c = 0;
    while (c < AREA_N) begin
      xmiss = (rq.x1 <= ring_left[i]) || (ring_right[i] <= rq.x0);
      ymiss = (rq.y1 <= ring_top[i]) || (ring_bottom[i] <= rq.y0);
      if (!xmiss && !ymiss)
        break;
      if (rq.used >= ring_pos[i])
        return res;
      i = (i + AREA_N - 1) % AREA_N;
      c++;
    end
    if (c == 0) begin
      res.dec = DEC_FULL;
    end else begin
      i = (i + 1) % AREA_N;
      res.dec = DEC_WAIT;
      res.tgt = ring_pos[i] + 32'd1;
    end
    return res;
  endfunction

  function automatic void apply_beat(draw_req_t rq);
    case (rq.kind)
      REQ_ADD_RECT:  record_area(rq.pos, rq.fresh, rq.x0, rq.y0, rq.x1, rq.y1);
      REQ_ADD_WORDS: record_area(rq.pos, rq.fresh, rq.tl[9:0], rq.tl[18:10],
                                 {1'b0, rq.br[9:0]} + 11'd1, {1'b0, rq.br[18:10]} + 10'd1);
      REQ_SCAN:      exp_verdicts.push_back(predict_scan(rq));
      default: ;
    endcase
  endfunction

  function automatic draw_req_t random_req();
    draw_req_t rq;
    rq.kind  = 2'($urandom_range(0, 3));
    rq.pos   = $urandom;
    rq.fresh = 1'($urandom_range(0, 1));
    rq.x0    = XW'($urandom);
    rq.y0    = YW'($urandom);
    rq.x1    = X1W'($urandom);
    rq.y1    = Y1W'($urandom);
    rq.tl    = $urandom;
    rq.br    = $urandom;
    rq.used  = $urandom;
    rq.added = $urandom;
    rq.idle  = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  function automatic draw_req_t rect_req(logic [PosW-1:0] pos, logic fresh, int x0, int y0,
                                         int x1, int y1);
    draw_req_t rq;
    rq = random_req();
    rq.kind  = REQ_ADD_RECT;
    rq.pos   = pos;
    rq.fresh = fresh;
    rq.x0    = XW'(x0);
    rq.y0    = YW'(y0);
    rq.x1    = X1W'(x1);
    rq.y1    = Y1W'(y1);
    return rq;
  endfunction

  function automatic draw_req_t words_req(logic [PosW-1:0] pos, logic fresh, logic [31:0] tl,
                                          logic [31:0] br);
    draw_req_t rq;
    rq = random_req();
    rq.kind  = REQ_ADD_WORDS;
    rq.pos   = pos;
    rq.fresh = fresh;
    rq.tl    = tl;
    rq.br    = br;
    return rq;
  endfunction

  function automatic draw_req_t scan_req(int x0, int y0, int x1, int y1,
                                         logic [PosW-1:0] used, logic [PosW-1:0] added,
                                         logic idle);
    draw_req_t rq;
    rq = random_req();
    rq.kind  = REQ_SCAN;
    rq.x0    = XW'(x0);
    rq.y0    = YW'(y0);
    rq.x1    = X1W'(x1);
    rq.y1    = Y1W'(y1);
    rq.used  = used;
    rq.added = added;
    rq.idle  = idle;
    return rq;
  endfunction

  // Driver: bursts of beats separated by random gaps.
  int        burst_left = 1;
  int        gap_left = 0;
  draw_req_t cur_req;

  always @(posedge clk_i or negedge rst_ni) begin
    draw_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        apply_beat(cur_req);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (req_queue.size() != 0) begin
          nxt = req_queue.pop_front();
          cur_req = nxt;
          in_valid_i      <= 1'b1;
          req_type_i      <= nxt.kind;
          stream_pos_i    <= nxt.pos;
          force_new_i     <= nxt.fresh;
          rect_x0_i       <= nxt.x0;
          rect_y0_i       <= nxt.y0;
          rect_x1_i       <= nxt.x1;
          rect_y1_i       <= nxt.y1;
          area_word_tl_i  <= nxt.tl;
          area_word_br_i  <= nxt.br;
          consumed_pos_i  <= nxt.used;
          added_pos_i     <= nxt.added;
          consumer_idle_i <= nxt.idle;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and stalls the output in changing modes.
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk_i) begin
    scan_verdict_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_verdicts.size() == 0) begin
        $error("unexpected result: decision %0d target_pos %0h", decision_o, target_pos_o);
        errors++;
      end else begin
        e = exp_verdicts.pop_front();
        if (decision_o !== e.dec) begin
          $error("decision: expected %0d, actual %0d", e.dec, decision_o);
          errors++;
        end
        if (target_pos_o !== e.tgt) begin
          $error("target_pos: expected %0h, actual %0h", e.tgt, target_pos_o);
          errors++;
        end
      end
    end
    if (mode_left <= 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(10, 80);
    end
    mode_left--;
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin
    int unsigned     k;
    int              ep;
    int              roll;
    int              x0;
    int              y0;
    int              xe;
    int              ye;
    logic [PosW-1:0] cur;
    logic [PosW-1:0] used;
    logic [31:0]     tl;
    logic [31:0]     br;
    logic            idle;

    for (k = 0; k < AREA_N; k++) begin
      ring_pos[k]    = '0;
      ring_left[k]   = '0;
      ring_top[k]    = '0;
      ring_right[k]  = '0;
      ring_bottom[k] = '0;
    end
    newest_slot = 0;

    // directed: empty ring, idle cases, wrapping scanout
    req_queue.push_back(scan_req(0, 0, 1, 1, 32'd0, 32'd5, 1'b0));
    req_queue.push_back(scan_req(5, 5, 9, 9, 32'h1234_5678, 32'h1234_5678, 1'b1));
    req_queue.push_back(scan_req(5, 5, 9, 9, 32'h1234_5678, 32'h1234_5679, 1'b1));
    req_queue.push_back(scan_req(0, 0, 1025, 10, 32'd0, 32'd1, 1'b0));
    req_queue.push_back(scan_req(0, 0, 10, 513, 32'd0, 32'd1, 1'b0));
    req_queue.push_back(scan_req(1023, 511, 2047, 1023, 32'hFFFF_FFFF, 32'd0, 1'b0));
    req_queue.push_back(scan_req(0, 0, 1024, 512, 32'd0, 32'd1, 1'b0));
    // fill the ring: a jump, a same-entry update, a forced entry, word forms
    req_queue.push_back(rect_req(32'd10, 1'b0, 0, 0, 100, 100));
    req_queue.push_back(rect_req(32'd11, 1'b0, 50, 50, 200, 200));
    req_queue.push_back(rect_req(32'd11, 1'b1, 300, 200, 400, 300));
    req_queue.push_back(words_req(32'd20, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF));
    req_queue.push_back(words_req(32'd30, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000));
    req_queue.push_back(rect_req(32'd40, 1'b0, 1023, 511, 2047, 1023));
    // miss then drained, hit further back, hit at the newest entry
    req_queue.push_back(scan_req(0, 0, 10, 10, 32'd35, 32'd50, 1'b0));
    req_queue.push_back(scan_req(0, 0, 10, 10, 32'd25, 32'd50, 1'b0));
    req_queue.push_back(scan_req(1023, 511, 1024, 512, 32'd5, 32'd50, 1'b0));
    // wrap the ring so the oldest entry is newer than the consumer
    req_queue.push_back(rect_req(32'd50, 1'b1, 1, 1, 2, 2));
    req_queue.push_back(rect_req(32'd60, 1'b1, 3, 3, 4, 4));
    req_queue.push_back(rect_req(32'd70, 1'b1, 5, 5, 6, 6));
    req_queue.push_back(scan_req(0, 0, 10, 10, 32'd5, 32'd80, 1'b0));
    // position wrapping past zero stays in the same entry
    req_queue.push_back(rect_req(32'hFFFF_FFFF, 1'b1, 600, 100, 700, 200));
    req_queue.push_back(rect_req(32'd0, 1'b0, 620, 120, 680, 180));
    req_queue.push_back(scan_req(650, 150, 660, 160, 32'hFFFF_FFFE, 32'd3, 1'b0));
    begin
      draw_req_t junk;
      junk = random_req();
      junk.kind = ReqUnused;
      req_queue.push_back(junk);
    end

    // random: episodes of consistent streams with random content, plus noise
    for (ep = 0; ep < 24; ep++) begin
      cur = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
      for (k = 0; k < 30; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          cur = cur + (($urandom_range(0, 9) == 0) ? $urandom_range(2, 1000)
                                                   : $urandom_range(0, 2));
          x0 = $urandom_range(0, 1023);
          y0 = $urandom_range(0, 511);
          xe = x0 + $urandom_range(1, 300);
          ye = y0 + $urandom_range(1, 200);
          if (xe > 1024) xe = 1024;
          if (ye > 512) ye = 512;
          if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 9) == 0) begin
              xe = $urandom_range(0, 2047);
              ye = $urandom_range(0, 1023);
            end
            req_queue.push_back(rect_req(cur, $urandom_range(0, 7) == 0, x0, y0, xe, ye));
          end else begin
            tl = $urandom;
            br = $urandom;
            tl[9:0]   = XW'(x0);
            tl[18:10] = YW'(y0);
            br[9:0]   = XW'(xe - 1);
            br[18:10] = YW'(ye - 1);
            req_queue.push_back(words_req(cur, $urandom_range(0, 7) == 0, tl, br));
          end
        end else if (roll < 90) begin
          used = cur - $urandom_range(0, 24);
          idle = ($urandom_range(0, 9) == 0);
          x0 = $urandom_range(0, 1023);
          y0 = $urandom_range(0, 511);
          xe = x0 + $urandom_range(1, 400);
          ye = y0 + $urandom_range(1, 300);
          if ($urandom_range(0, 11) != 0) begin
            if (xe > 1024) xe = 1024;
            if (ye > 512) ye = 512;
          end
          req_queue.push_back(scan_req(x0, y0, xe, ye, used,
                                       (idle && $urandom_range(0, 1)) ? used : cur, idle));
        end else begin
          req_queue.push_back(random_req());
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sampled away from the driving edge so queue and valid agree
    while (req_queue.size() != 0 || in_valid_i || exp_verdicts.size() != 0)
      @(negedge clk_i);
    repeat (AREA_N * 3) @(posedge clk_i);
    if (errors == 0 && exp_verdicts.size() == 0)
      $display("** draw_area_scanout_hazard_tracker: PASSED **");
    else
      $display("** draw_area_scanout_hazard_tracker: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** draw_area_scanout_hazard_tracker: FAILED **");
    $finish;
  end

endmodule
